// File: rtl/kptl_pkg.sv
`default_nettype none

package kptl_pkg;

    localparam int CFG_W = 9;

    localparam logic [1:0] CMD_OBSERVE = 2'd0;
    localparam logic [1:0] CMD_CLEAR   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [63:0]        peer_key;
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [31:0]        now_ms;
        logic [7:0]         slot_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         slot;
        logic               is_new;
        logic               entry_used;
        logic [63:0]        entry_key;
        logic [47:0]        entry_mac;
        logic signed [7:0]  entry_rssi;
        logic [31:0]        entry_first_ms;
        logic [31:0]        entry_last_ms;
        logic [31:0]        entry_hits;
        logic [31:0]        distinct_count;
    } t_out_word;

    typedef struct packed {
        logic               used;
        logic [63:0]        key;
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [31:0]        alloc_ms;
        logic [31:0]        last_ms;
        logic [31:0]        hits;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/kptl_ram.sv
`default_nettype none

module kptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/keyed_peer_table_lru_unit.sv
// Peer table with least-recently-seen replacement, one entry per key fingerprint.
// Input channel: i_in_valid / o_in_stall carry one command word (observe, clear,
// read). Output channel: o_out_valid / i_out_stall return exactly one result word
// per command. Config channel: i_cfg_valid / o_cfg_ready write slots_in_use;
// write it only while the block is idle.
// An observe walks the active slots through one RAM read port, one slot per
// cycle, comparing key and last time in a single shared compare stage; the walk
// ends early on a key match. A read fetches the addressed slot from RAM, and a
// clear sweeps every slot and zeroes the distinct count.
// One command is in flight at a time: o_in_stall is high from acceptance until
// the result is loaded into the output register. A finished result waits there
// while i_out_stall is high, and the next command may be taken meanwhile.
// Reset (synchronous, active low) sets slots_in_use to 256 (capped at
// TABLE_SLOTS), zeroes the distinct count and runs a clearing pass over
// every slot, during which no command is accepted.
`default_nettype none

module keyed_peer_table_lru_unit #(
    parameter int TABLE_SLOTS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire kptl_pkg::t_in_word    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output kptl_pkg::t_out_word        o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [kptl_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NW = $clog2(TABLE_SLOTS + 1);
    localparam int CW = (NW > kptl_pkg::CFG_W) ? NW : kptl_pkg::CFG_W;
    localparam int EW = $bits(kptl_pkg::t_entry);
    localparam int RST_ACTIVE = (TABLE_SLOTS < 256) ? TABLE_SLOTS : 256;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_RDA,
        S_RDB,
        S_RES
    } t_state;

    t_state               r_state;
    kptl_pkg::t_in_word   r_item;
    kptl_pkg::t_out_word  r_res;
    logic [NW-1:0]        r_active;
    logic [NW-1:0]        r_idx;
    logic                 r_clr_cmd;
    logic [31:0]          r_alloc;
    logic                 r_ev_valid;
    logic [IW-1:0]        r_ev_idx;
    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    kptl_pkg::t_entry     r_old;
    logic                 r_free;
    logic [IW-1:0]        r_free_idx;
    logic [31:0]          r_min;
    logic [IW-1:0]        r_min_idx;

    logic                 issue;
    logic                 accept;
    logic                 out_free;
    logic                 ram_wr_en;
    logic [IW-1:0]        ram_wr_addr;
    kptl_pkg::t_entry     ram_wr_data;
    logic                 ram_rd_en;
    logic [IW-1:0]        ram_rd_addr;
    kptl_pkg::t_entry     ram_q;
    logic [CW-1:0]        cfg_wide;
    logic [NW-1:0]        cfg_active;
    logic [IW-1:0]        victim;
    kptl_pkg::t_entry     upd_entry;
    logic                 rd_in_table;
    kptl_pkg::t_out_word  base_res;
    kptl_pkg::t_out_word  rd_res;

    kptl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign issue       = (r_state == S_SCAN) && (r_idx < r_active) && !r_hit;
    assign rd_in_table = CW'(r_item.slot_index) < CW'(TABLE_SLOTS);

    always_comb begin
        cfg_wide = CW'(i_cfg_data);
        priority if (cfg_wide == '0) begin
            cfg_active = NW'(1);
        end else if (cfg_wide > CW'(TABLE_SLOTS)) begin
            cfg_active = NW'(TABLE_SLOTS);
        end else begin
            cfg_active = NW'(cfg_wide);
        end
    end

    always_comb begin
        priority if (r_hit) begin
            victim = r_hit_idx;
        end else if (r_free) begin
            victim = r_free_idx;
        end else begin
            victim = r_min_idx;
        end

        upd_entry.used    = 1'b1;
        upd_entry.key     = r_item.peer_key;
        upd_entry.mac     = r_item.mac;
        upd_entry.rssi    = r_item.rssi;
        upd_entry.last_ms = r_item.now_ms;
        if (r_hit) begin
            upd_entry.alloc_ms = r_old.alloc_ms;
            upd_entry.hits     = 32'(r_old.hits + 32'd1);
        end else begin
            upd_entry.alloc_ms = r_item.now_ms;
            upd_entry.hits     = 32'd1;
        end
    end

    always_comb begin
        base_res                = '0;
        base_res.distinct_count = r_alloc;
        rd_res                  = base_res;
        rd_res.slot             = r_item.slot_index;
        if (rd_in_table && ram_q.used) begin
            rd_res.entry_used     = 1'b1;
            rd_res.entry_key      = ram_q.key;
            rd_res.entry_mac      = ram_q.mac;
            rd_res.entry_rssi     = ram_q.rssi;
            rd_res.entry_first_ms = ram_q.alloc_ms;
            rd_res.entry_last_ms  = ram_q.last_ms;
            rd_res.entry_hits     = ram_q.hits;
        end
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx[IW-1:0];
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx[IW-1:0];
        unique case (r_state)
            S_CLR: begin
                ram_wr_en = 1'b1;
            end
            S_SCAN: begin
                ram_rd_en = issue;
            end
            S_UPD: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = victim;
                ram_wr_data = upd_entry;
            end
            S_RDA: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = IW'(r_item.slot_index);
            end
            S_IDLE, S_RDB, S_RES: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_clr_cmd   <= 1'b0;
            r_alloc     <= '0;
            r_active    <= NW'(RST_ACTIVE);
            r_ev_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= cfg_active;
            end
            if (o_out_valid && !i_out_stall && (r_state != S_RES)) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    if (r_idx == NW'(TABLE_SLOTS - 1)) begin
                        r_idx <= '0;
                        if (r_clr_cmd) begin
                            r_res   <= '0;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= NW'(r_idx + 1'b1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_item     <= i_in_data;
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_ev_valid <= 1'b0;
                        unique case (i_in_data.cmd)
                            kptl_pkg::CMD_OBSERVE: begin
                                r_state <= S_SCAN;
                            end
                            kptl_pkg::CMD_CLEAR: begin
                                r_clr_cmd <= 1'b1;
                                r_alloc   <= '0;
                                r_state   <= S_CLR;
                            end
                            kptl_pkg::CMD_READ: begin
                                r_state <= S_RDA;
                            end
                            default: begin
                                r_res   <= base_res;
                                r_state <= S_RES;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_ev_valid <= issue;
                    r_ev_idx   <= r_idx[IW-1:0];
                    if (issue) begin
                        r_idx <= NW'(r_idx + 1'b1);
                    end
                    if (r_ev_valid && !r_hit) begin
                        if (ram_q.used && (ram_q.key == r_item.peer_key)) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_ev_idx;
                            r_old     <= ram_q;
                        end
                        if (!ram_q.used && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_ev_idx;
                        end
                        if ((r_ev_idx == '0) || (ram_q.last_ms < r_min)) begin
                            r_min     <= ram_q.last_ms;
                            r_min_idx <= r_ev_idx;
                        end
                    end
                    if (!issue && !r_ev_valid) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_res.slot           <= 8'(victim);
                    r_res.is_new         <= !r_hit;
                    r_res.entry_used     <= 1'b1;
                    r_res.entry_key      <= upd_entry.key;
                    r_res.entry_mac      <= upd_entry.mac;
                    r_res.entry_rssi     <= upd_entry.rssi;
                    r_res.entry_first_ms <= upd_entry.alloc_ms;
                    r_res.entry_last_ms  <= upd_entry.last_ms;
                    r_res.entry_hits     <= upd_entry.hits;
                    if (r_hit) begin
                        r_res.distinct_count <= r_alloc;
                    end else begin
                        r_res.distinct_count <= 32'(r_alloc + 32'd1);
                        r_alloc              <= 32'(r_alloc + 32'd1);
                    end
                    r_state <= S_RES;
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_res   <= rd_res;
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_data  <= r_res;
                        r_clr_cmd   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
